// File: sv/sfpr_pkg.sv
`timescale 1ns / 1ps
package sfpr_pkg;
	localparam int FRAMES_DEF     = 64;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam int ADDR_W         = 48;
	localparam int CNT_W          = 32;
	localparam int CFG_W          = 6;
	localparam int CFG_IDX_W      = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECONDARY = 1'd1;

	localparam logic [1:0] WHERE_PRIMARY   = 2'd0;
	localparam logic [1:0] WHERE_SECONDARY = 2'd1;
	localparam logic [1:0] WHERE_MISS      = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;
endpackage

// File: sv/sfpr_if.sv
`timescale 1ns / 1ps
interface sfpr_in_if;
	logic        valid;
	logic        ready;
	logic [47:0] address;
	logic        is_write;
	modport source (output valid, address, is_write, input ready);
	modport sink (input valid, address, is_write, output ready);
endinterface

interface sfpr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  hit_where;
	logic        disk_read;
	logic        disk_write;
	logic [31:0] total_reads;
	logic [31:0] total_writes;
	logic [31:0] access_count;
	modport source (output valid, hit_where, disk_read, disk_write, total_reads,
		total_writes, access_count, input ready);
	modport sink (input valid, hit_where, disk_read, disk_write, total_reads,
		total_writes, access_count, output ready);
endinterface

// File: sv/segmented_fifo_page_replacement.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// cfg      in   cfg_we, cfg_index, cfg_data (primary_frames, secondary_frames)
// req      in   address, is_write
// rsp      out  hit_where, disk_read, disk_write, total_reads, total_writes,
//               access_count
// Each access is accepted and compared with all frames in parallel, then
// the segment cells are updated, then the result is held until transferred.
// The next access is accepted once the result has gone.
// arst_n clears counts and counters; frame contents need no reset.
module segmented_fifo_page_replacement #(
	parameter int FRAMES     = sfpr_pkg::FRAMES_DEF,
	parameter int PAGE_SHIFT = sfpr_pkg::PAGE_SHIFT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [0:0] cfg_index,
	input logic [5:0] cfg_data,
	sfpr_in_if.sink   req,
	sfpr_out_if.source rsp
);
	import sfpr_pkg::*;
	cmd_t cmd;

	sfpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd)
	);

	sfpr_dp #(.FRAMES(FRAMES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.address(req.address), .is_write(req.is_write),
		.hit_where(rsp.hit_where), .disk_read(rsp.disk_read),
		.disk_write(rsp.disk_write), .total_reads(rsp.total_reads),
		.total_writes(rsp.total_writes), .access_count(rsp.access_count)
	);
endmodule

// File: sv/sfpr_ctrl.sv
`timescale 1ns / 1ps
module sfpr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output sfpr_pkg::cmd_t  cmd
);
	import sfpr_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd.load   = 1'b0;
		cmd.update = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	property p_update_done;
		@(posedge clk) disable iff (!arst_n) state_q == ST_UPDATE |=> state_q == ST_OUT;
	endproperty
	assert property (p_update_done) else $error("update did not finish");
	property p_no_load_busy;
		@(posedge clk) disable iff (!arst_n) cmd.load |-> state_q == ST_IDLE;
	endproperty
	assert property (p_no_load_busy) else $error("load while busy");
	property p_out_follows;
		@(posedge clk) disable iff (!arst_n) cmd.update |=> out_valid;
	endproperty
	assert property (p_out_follows) else $error("result not shown after update");
endmodule

// File: sv/sfpr_dp.sv
`timescale 1ns / 1ps
module sfpr_dp #(
	parameter int FRAMES     = sfpr_pkg::FRAMES_DEF,
	parameter int PAGE_SHIFT = sfpr_pkg::PAGE_SHIFT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfpr_pkg::cmd_t              cmd,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [5:0]                  cfg_data,
	input  logic [47:0]                 address,
	input  logic                        is_write,
	output logic [1:0]                  hit_where,
	output logic                        disk_read,
	output logic                        disk_write,
	output logic [31:0]                 total_reads,
	output logic [31:0]                 total_writes,
	output logic [31:0]                 access_count
);
	import sfpr_pkg::*;
	localparam int PW = ADDR_W - PAGE_SHIFT;
	localparam int IW = $clog2(FRAMES);
	localparam int NW = $clog2(FRAMES + 1);

	logic [PW-1:0] p_page_q [FRAMES];
	logic          p_dirty_q [FRAMES];
	logic [PW-1:0] s_page_q [FRAMES];
	logic          s_dirty_q [FRAMES];
	logic [NW-1:0] p_cnt_q, s_cnt_q;
	logic [5:0]    pfr_q, sfr_q;
	logic [PW-1:0] page_q;
	logic          wr_q;
	logic [FRAMES-1:0] p_hit_q, s_hit_q;
	logic [31:0]   rd_cnt_q, wb_cnt_q, acc_cnt_q;
	logic [1:0]    where_q;
	logic          rd_q, wb_q;

	// capacities: zero acts as one, clip at FRAMES
	logic [NW:0] pcap, scap;
	always_comb begin
		pcap = (pfr_q == 6'd0) ? (NW+1)'(1) : (NW+1)'(pfr_q);
		scap = (sfr_q == 6'd0) ? (NW+1)'(1) : (NW+1)'(sfr_q);
		if (pcap > (NW+1)'(FRAMES)) pcap = (NW+1)'(FRAMES);
		if (scap > (NW+1)'(FRAMES)) scap = (NW+1)'(FRAMES);
	end

	// first-match index over hit vectors
	logic          p_any, s_any;
	logic [IW-1:0] p_idx, s_idx;
	always_comb begin
		p_any = 1'b0; s_any = 1'b0;
		p_idx = '0;   s_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (p_hit_q[i]) begin p_any = 1'b1; p_idx = IW'(i); end
			if (s_hit_q[i]) begin s_any = 1'b1; s_idx = IW'(i); end
		end
	end

	// decisions for the update cycle
	logic p_full, s_full, do_hand, do_evict, do_push, s_last_dirty, push_dirty;
	logic [NW-1:0] p_after, s_after;
	always_comb begin
		p_full   = (NW+1)'(p_cnt_q) >= pcap;
		s_full   = (NW+1)'(s_cnt_q) >= scap;
		do_evict = !p_any && !s_any && p_full && s_full && s_cnt_q != '0;
		s_last_dirty = s_dirty_q[IW'(s_cnt_q - NW'(1))];
		do_push  = !p_any;
		push_dirty = s_any ? (s_dirty_q[s_idx] | wr_q) : wr_q;
		s_after  = s_cnt_q - NW'(s_any) - NW'(do_evict);
		do_hand  = !p_any && p_full && p_cnt_q != '0 && s_after < NW'(FRAMES);
		p_after  = p_cnt_q - NW'(do_hand);
		if (do_push && p_after < NW'(FRAMES)) p_after = p_after + NW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfr_q     <= 6'd48;
			sfr_q     <= 6'd16;
			p_cnt_q   <= '0;
			s_cnt_q   <= '0;
			rd_cnt_q  <= '0;
			wb_cnt_q  <= '0;
			acc_cnt_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_PRIMARY[0:0]) pfr_q <= cfg_data;
			if (cfg_we && cfg_index == REG_SECONDARY[0:0]) sfr_q <= cfg_data;
			if (cmd.update) begin
				if (acc_cnt_q != '1) acc_cnt_q <= acc_cnt_q + 32'd1;
				if (!p_any && !s_any && rd_cnt_q != '1) rd_cnt_q <= rd_cnt_q + 32'd1;
				if (do_evict && s_last_dirty && wb_cnt_q != '1)
					wb_cnt_q <= wb_cnt_q + 32'd1;
				p_cnt_q <= p_after;
				s_cnt_q <= s_after + NW'(do_hand);
			end
		end
	end

	logic [NW-1:0] p_base;
	assign p_base = p_cnt_q - NW'(do_hand);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= address[ADDR_W-1:PAGE_SHIFT];
			wr_q   <= is_write;
			for (int i = 0; i < FRAMES; i++) begin
				p_hit_q[i] <= (NW'(i) < p_cnt_q) && p_page_q[i] == address[ADDR_W-1:PAGE_SHIFT];
				s_hit_q[i] <= (NW'(i) < s_cnt_q) && s_page_q[i] == address[ADDR_W-1:PAGE_SHIFT];
			end
		end
		if (cmd.update) begin
			where_q <= p_any ? WHERE_PRIMARY : (s_any ? WHERE_SECONDARY : WHERE_MISS);
			rd_q    <= !p_any && !s_any;
			wb_q    <= do_evict && s_last_dirty;
			if (p_any && wr_q) p_dirty_q[p_idx] <= 1'b1;
			// primary cells: push at tail, else shift down on hand-off
			for (int i = 0; i < FRAMES; i++) begin
				if (do_push && NW'(i) == p_base) begin
					p_page_q[i]  <= page_q;
					p_dirty_q[i] <= push_dirty;
				end else if (do_hand && i < FRAMES - 1) begin
					p_page_q[i]  <= p_page_q[i+1];
					p_dirty_q[i] <= p_dirty_q[i+1];
				end
			end
			// secondary cells: close the hit gap, then shift up on hand-off
			for (int i = 0; i < FRAMES; i++) begin
				if (do_hand) begin
					if (i == 0) begin
						s_page_q[i]  <= p_page_q[0];
						s_dirty_q[i] <= p_dirty_q[0];
					end else if (s_any && IW'(i) > s_idx) begin
						s_page_q[i]  <= s_page_q[i];
						s_dirty_q[i] <= s_dirty_q[i];
					end else begin
						s_page_q[i]  <= s_page_q[i-1];
						s_dirty_q[i] <= s_dirty_q[i-1];
					end
				end else if (s_any && IW'(i) >= s_idx && i < FRAMES - 1) begin
					s_page_q[i]  <= s_page_q[i+1];
					s_dirty_q[i] <= s_dirty_q[i+1];
				end
			end
		end
	end

	assign hit_where    = where_q;
	assign disk_read    = rd_q;
	assign disk_write   = wb_q;
	assign total_reads  = rd_cnt_q;
	assign total_writes = wb_cnt_q;
	assign access_count = acc_cnt_q;

	property p_cnt_bound;
		@(posedge clk) disable iff (!arst_n) p_cnt_q <= NW'(FRAMES) && s_cnt_q <= NW'(FRAMES);
	endproperty
	assert property (p_cnt_bound) else $error("segment count overflow");
	property p_one_hit;
		@(posedge clk) disable iff (!arst_n) cmd.update |-> $onehot0(p_hit_q);
	endproperty
	assert property (p_one_hit) else $error("duplicate primary page");
	property p_wb_miss;
		@(posedge clk) disable iff (!arst_n) $past(cmd.update) && wb_q |-> rd_q;
	endproperty
	assert property (p_wb_miss) else $error("write-back without miss");
endmodule
